@@ design/scpd_pkg.sv @@
// Package for the sync checksum packet deframer.
// Holds shared constants, result kind codes and the controller/datapath interface structs.
// No dependencies.
package scpd_pkg;

   localparam int          PAYLOAD_BYTES_DEFAULT = 1;
   localparam int          PAYLOAD_OFFSET        = 4;
   localparam int          TRAILER_BYTES         = 2;
   localparam logic [7:0]  SYNC_RESET            = 8'hAA;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REJECT  = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic scan;
      logic scan_clr;
      logic idx_load_zero;
      logic idx_load_pay;
      logic idx_inc;
      logic rsp_load_pay;
      logic rsp_load_rej;
      logic clear_window;
      logic realign;
   } cmd_type;

   typedef struct packed {
      logic window_last;
      logic idx_last;
      logic idx_pay_last;
      logic good;
   } sts_type;

endpackage

@@ design/scpd_datapath.sv @@
// Datapath of the packet deframer: circular window memory, checksum scan, realignment.
// Driven by scpd_ctrl through cmd_type; depends on scpd_pkg.
module scpd_datapath
   import scpd_pkg::*;
#(
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output sts_type    sts,
   input  logic [7:0] req_stream_byte,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output logic       rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last
);

   localparam int PacketLen = PAYLOAD_OFFSET + PAYLOAD_BYTES + TRAILER_BYTES;
   localparam int AddrW     = $clog2(PacketLen);

   localparam logic [AddrW:0]   LenExt     = (AddrW + 1)'(PacketLen);
   localparam logic [AddrW-1:0] LastIdx    = AddrW'(PacketLen - 1);
   localparam logic [AddrW-1:0] TrlHiIdx   = AddrW'(PacketLen - TRAILER_BYTES);
   localparam logic [AddrW-1:0] PayLastIdx = AddrW'(PacketLen - TRAILER_BYTES - 1);
   localparam logic [AddrW-1:0] PayIdx     = AddrW'(PAYLOAD_OFFSET);

   function automatic logic [AddrW-1:0] wrap_addr(input logic [AddrW:0] s);
      logic [AddrW:0] r;
      r = (s >= LenExt) ? (s - LenExt) : s;
      return r[AddrW-1:0];
   endfunction

   logic [7:0]       win_mem [PacketLen];
   logic [7:0]       mem_q_ff;
   logic [7:0]       sync_ff;
   logic [AddrW-1:0] base_ff;
   logic [AddrW-1:0] fill_ff;
   logic [AddrW-1:0] idx_ff;
   logic             rd_valid_ff;
   logic [AddrW-1:0] rd_idx_ff;
   logic [15:0]      sum_ff;
   logic [7:0]       trl_hi_ff;
   logic [7:0]       trl_lo_ff;
   logic             sync_ok_ff;
   logic             found_ff;
   logic [AddrW-1:0] found_idx_ff;
   logic             kind_ff;
   logic [7:0]       byte_ff;
   logic             last_ff;

   logic [AddrW-1:0] wr_addr;
   logic [AddrW-1:0] rd_addr;
   logic [AddrW:0]   fill_after_realign;

   assign wr_addr = wrap_addr({1'b0, base_ff} + {1'b0, fill_ff});
   assign rd_addr = wrap_addr({1'b0, base_ff} + {1'b0, idx_ff});
   assign fill_after_realign = LenExt - {1'b0, found_idx_ff};

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         win_mem[wr_addr] <= req_stream_byte;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= win_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
      end else if (csr_we) begin
         sync_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.clear_window) begin
         base_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.realign) begin
         if (found_ff) begin
            base_ff <= wrap_addr({1'b0, base_ff} + {1'b0, found_idx_ff});
            fill_ff <= fill_after_realign[AddrW-1:0];
         end else begin
            base_ff <= '0;
            fill_ff <= '0;
         end
      end else if (cmd.wr_en && (fill_ff != LastIdx)) begin
         fill_ff <= fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         priority if (cmd.idx_load_zero) begin
            idx_ff <= '0;
         end else if (cmd.idx_load_pay) begin
            idx_ff <= PayIdx;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end else begin
            idx_ff <= idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en && cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      if (cmd.scan_clr) begin
         sum_ff   <= '0;
         found_ff <= 1'b0;
      end else if (rd_valid_ff) begin
         priority if (rd_idx_ff == '0) begin
            sync_ok_ff <= (mem_q_ff == sync_ff);
            sum_ff     <= {8'd0, mem_q_ff};
         end else if (rd_idx_ff < TrlHiIdx) begin
            sum_ff <= sum_ff + {8'd0, mem_q_ff};
         end else if (rd_idx_ff == TrlHiIdx) begin
            trl_hi_ff <= mem_q_ff;
         end else begin
            trl_lo_ff <= mem_q_ff;
         end
         if ((rd_idx_ff != '0) && (mem_q_ff == sync_ff) && !found_ff) begin
            found_ff     <= 1'b1;
            found_idx_ff <= rd_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load_pay) begin
         kind_ff <= KIND_PAYLOAD;
         byte_ff <= mem_q_ff;
         last_ff <= (idx_ff == PayLastIdx);
      end else if (cmd.rsp_load_rej) begin
         kind_ff <= KIND_REJECT;
         byte_ff <= 8'd0;
         last_ff <= 1'b1;
      end
   end

   assign sts.window_last  = (fill_ff == LastIdx);
   assign sts.idx_last     = (idx_ff == LastIdx);
   assign sts.idx_pay_last = (idx_ff == PayLastIdx);
   assign sts.good         = sync_ok_ff && (sum_ff == {trl_hi_ff, trl_lo_ff});

   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_last         = last_ff;

endmodule

@@ design/scpd_ctrl.sv @@
// Controller state machine of the packet deframer.
// Sequences fill, checksum scan, payload output and realignment; depends on scpd_pkg.
module scpd_ctrl
   import scpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_DECIDE,
      S_PAY_RD,
      S_PAY_LOAD,
      S_PAY_SEND,
      S_REJ_SEND
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.wr_en = 1'b1;
               if (sts.window_last) begin
                  cmd.idx_load_zero = 1'b1;
                  cmd.scan_clr      = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cmd.rd_en = 1'b1;
            cmd.scan  = 1'b1;
            if (!sts.idx_last) begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_SCAN_END: begin
         end
         S_DECIDE: begin
            if (sts.good) begin
               cmd.idx_load_pay = 1'b1;
            end else begin
               cmd.rsp_load_rej = 1'b1;
            end
         end
         S_PAY_RD: begin
            cmd.rd_en = 1'b1;
         end
         S_PAY_LOAD: begin
            cmd.rsp_load_pay = 1'b1;
         end
         S_PAY_SEND: begin
            if (!rsp_stall) begin
               if (sts.idx_pay_last) begin
                  cmd.clear_window = 1'b1;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         S_REJ_SEND: begin
            if (!rsp_stall) begin
               cmd.realign = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && sts.window_last) begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (sts.idx_last) begin
                  state_ff <= S_SCAN_END;
               end
            end
            S_SCAN_END: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (sts.good) begin
                  state_ff <= S_PAY_RD;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_REJ_SEND;
               end
            end
            S_PAY_RD: begin
               state_ff <= S_PAY_LOAD;
            end
            S_PAY_LOAD: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_PAY_SEND;
            end
            S_PAY_SEND: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= sts.idx_pay_last ? S_IDLE : S_PAY_RD;
               end
            end
            S_REJ_SEND: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/sync_checksum_packet_deframer.sv @@
// Top level of the sync checksum packet deframer.
// Joins scpd_ctrl and scpd_datapath; depends on scpd_pkg.
//
// A byte that does not complete the packet window is written into the window memory, and
// the block is ready for the next byte in the following cycle. The byte that completes a
// window of PAYLOAD_BYTES + 6 bytes starts a check that reads the window memory one byte
// per cycle; after the scan end and decide states a reject result is shown, or the first
// payload byte of a good packet after the payload read and load states. A good packet then
// gives its payload bytes one at a time, each through the read, load and send steps on the
// single read port of the window memory, and a bad packet gives one reject result; each
// result also waits for as long as rsp_stall stays high, and no new byte is taken until the
// block is idle again. After a reject the window realigns to the next sync byte without
// moving any data. The sync byte register may be written only while no packet is in check.
module sync_checksum_packet_deframer
   import scpd_pkg::*;
#(
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_stream_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   scpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   scpd_datapath #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_stream_byte  (req_stream_byte),
      .csr_we           (csr_valid && csr_ready),
      .csr_wdata        (csr_wdata),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

endmodule

@@ tb/sync_checksum_packet_deframer_tb.sv @@
// Self-checking testbench for sync_checksum_packet_deframer.
// Feeds framed and corrupted byte streams, predicts payload and reject results in a local
// deframer copy, and checks them under random idling; depends on scpd_pkg and the RTL.
`timescale 1ns / 1ps

module sync_checksum_packet_deframer_tb
   import scpd_pkg::*;
();

   localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEFAULT;
   localparam int PACKET_LEN    = PAYLOAD_OFFSET + PAYLOAD_BYTES + TRAILER_BYTES;
   localparam int SETTLE_CYCLES = 4 * (PAYLOAD_BYTES + 9) + 3 * PAYLOAD_BYTES + 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 300000;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload;
      logic       last;
   } result_type;

   typedef enum int {FRAME_CLEAN, FRAME_BAD_SUM, FRAME_BAD_SYNC, FRAME_CUT} frame_flaw_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_stream_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic       rsp_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_wdata = 8'h00;

   logic [7:0]  window_copy [PACKET_LEN];
   int unsigned window_fill = 0;
   logic [7:0]  sync_value = SYNC_RESET;
   result_type  expected_results [$];

   int error_count     = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int good_packets    = 0;
   int reject_count    = 0;
   int realign_count   = 0;
   int sync_writes     = 0;
   int cycle_count     = 0;

   bit sender_gaps_on = 1'b1;
   int burst_left     = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int stall_mode     = 0;
   int stall_phase    = 0;

   sync_checksum_packet_deframer #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Local deframer: takes one accepted byte and queues the results it causes.
   task automatic deframe_byte(input logic [7:0] stream_byte);
      int unsigned sum;
      int unsigned trailer;
      int unsigned sync_pos;
      result_type  res;
      if (window_fill >= PACKET_LEN) begin
         window_fill = 0;
      end
      window_copy[window_fill] = stream_byte;
      window_fill++;
      if (window_fill < PACKET_LEN) begin
         return;
      end
      sum = 0;
      for (int k = 0; k < PACKET_LEN - 2; k++) begin
         sum = (sum + 32'(window_copy[k])) & 32'h0000_FFFF;
      end
      trailer = 32'({window_copy[PACKET_LEN - 2], window_copy[PACKET_LEN - 1]});
      if (window_copy[0] == sync_value && sum == trailer) begin
         for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            res.kind    = KIND_PAYLOAD;
            res.payload = window_copy[PAYLOAD_OFFSET + k];
            res.last    = (k == PAYLOAD_BYTES - 1);
            expected_results.push_back(res);
         end
         window_fill = 0;
         good_packets++;
      end else begin
         res.kind    = KIND_REJECT;
         res.payload = 8'h00;
         res.last    = 1'b1;
         expected_results.push_back(res);
         reject_count++;
         sync_pos = 0;
         for (int k = 1; k < PACKET_LEN; k++) begin
            if (sync_pos == 0 && window_copy[k] == sync_value) begin
               sync_pos = k;
            end
         end
         if (sync_pos != 0) begin
            for (int k = 0; k + sync_pos < PACKET_LEN; k++) begin
               window_copy[k] = window_copy[k + sync_pos];
            end
            window_fill = PACKET_LEN - sync_pos;
            realign_count++;
         end else begin
            window_fill = 0;
         end
      end
   endtask

   always @(posedge clock) begin : result_checker
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_kind, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_kind !== want.kind) begin
               report_mismatch("kind", rsp_kind, want.kind);
            end
            if (rsp_payload_byte !== want.payload) begin
               report_mismatch("payload_byte", rsp_payload_byte, want.payload);
            end
            if (rsp_last !== want.last) begin
               report_mismatch("last", rsp_last, want.last);
            end
         end
      end
   end

   // The receiver switches between stall styles and serves long holds on request.
   always @(negedge clock) begin : rsp_stall_gen
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_left == 0 && hold_served < hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         stall_phase++;
         if (stall_phase % 97 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= 1'($urandom_range(0, 1));
               2: rsp_stall <= (stall_phase % 7) < 3;
               default: rsp_stall <= $urandom_range(0, 9) < 8;
            endcase
         end
      end
   end

   task automatic send_byte(input logic [7:0] stream_byte);
      int gap;
      if (burst_left == 0) begin
         gap = sender_gaps_on ? $urandom_range(1, 8) : 0;
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_stream_byte <= stream_byte;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
      deframe_byte(stream_byte);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_sync(input logic [7:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      sync_value = value;
      sync_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] header_byte();
      return ($urandom_range(0, 5) == 0) ? sync_value : 8'($urandom_range(0, 255));
   endfunction

   task automatic send_frame(input frame_flaw_type flaw);
      logic [7:0]  frame [PACKET_LEN];
      logic [15:0] sum;
      int          length;
      sum = 16'h0000;
      frame[0] = sync_value;
      if (flaw == FRAME_BAD_SYNC) begin
         frame[0] = sync_value ^ 8'($urandom_range(1, 255));
      end
      for (int k = 1; k < PACKET_LEN - 2; k++) begin
         frame[k] = (k < PAYLOAD_OFFSET) ? header_byte() : 8'($urandom_range(0, 255));
      end
      for (int k = 0; k < PACKET_LEN - 2; k++) begin
         sum = sum + 16'(frame[k]);
      end
      if (flaw == FRAME_BAD_SUM) begin
         sum = sum ^ 16'($urandom_range(1, 65535));
      end
      frame[PACKET_LEN - 2] = sum[15:8];
      frame[PACKET_LEN - 1] = sum[7:0];
      length = (flaw == FRAME_CUT) ? $urandom_range(1, PACKET_LEN - 1) : PACKET_LEN;
      for (int k = 0; k < length; k++) begin
         send_byte(frame[k]);
      end
   endtask

   task automatic test_good_packet();
      send_byte(8'hAA);
      repeat (4) send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hAA);
   endtask

   task automatic test_reject_without_sync();
      send_byte(8'h55);
      repeat (6) send_byte(8'hFF);
   endtask

   // A bad checksum with a sync byte inside the window, then the realigned window
   // is completed into a good packet carrying payload 0xFF.
   task automatic test_realign_after_reject();
      send_byte(8'hAA);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'hAA);
      send_byte(8'h05);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'hAE);
   endtask

   task automatic test_backpressure();
      drain_results();
      sender_gaps_on = 1'b0;
      hold_requests++;
      repeat (4) send_frame(FRAME_CLEAN);
      drain_results();
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic(input logic [7:0] sync_setting, input int byte_budget,
                                      input bit gaps);
      int pick;
      int stop_at;
      write_sync(sync_setting);
      sender_gaps_on = gaps;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            send_frame(FRAME_CLEAN);
         end else if (pick == 6) begin
            send_frame(FRAME_BAD_SUM);
         end else if (pick == 7) begin
            send_frame(FRAME_BAD_SYNC);
         end else if (pick == 8) begin
            send_frame(FRAME_CUT);
         end else begin
            repeat ($urandom_range(1, 5)) send_byte(header_byte());
         end
      end
      sender_gaps_on = 1'b1;
   endtask

   initial begin : main
      @(negedge clock);
      while (reset) begin
         @(negedge clock);
      end
      test_good_packet();
      test_reject_without_sync();
      test_realign_after_reject();
      test_backpressure();
      test_random_traffic(8'h00, 75, 1'b1);
      test_random_traffic(8'hFF, 75, 1'b1);
      test_random_traffic(8'($urandom_range(0, 255)), 75, 1'b1);
      test_random_traffic(SYNC_RESET, 55, 1'b0);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch("results never produced", 0, expected_results.size());
      end
      $display("Sent %0d stream bytes under %0d sync settings; checked %0d results.",
               bytes_sent, sync_writes + 1, results_checked);
      $display("Saw %0d good packets, %0d rejects and %0d realigned windows.",
               good_packets, reject_count, realign_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
